// ===== rtl/gradient_non_maximum_suppression_assert.svh =====
// Assertion macros shared by the gradient non-maximum suppression RTL.
`ifndef GRADIENT_NON_MAXIMUM_SUPPRESSION_ASSERT_SVH
`define GRADIENT_NON_MAXIMUM_SUPPRESSION_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GNMS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GNMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gnms_pkg.sv =====
// Package: constants, types and direction quantiser for gradient non-maximum suppression.
`default_nettype none

package gnms_pkg;

  localparam int MAX_WIDTH_DEF      = 4096;
  localparam int MAG_BITS_DEF       = 16;
  localparam int ANG_BITS           = 10;
  localparam int COORD_BITS         = 12;
  localparam int CFG_BITS           = 13;
  localparam int HEIGHT_MAX         = 4096;
  localparam int DIM_MIN            = 3;
  localparam int FRAME_WIDTH_RESET  = 640;
  localparam int FRAME_HEIGHT_RESET = 480;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int CFG_AW      = 3;
  localparam int APB_DW      = 32;
  localparam int REG_SEL_BIT = 2;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // direction boundaries, half-degree units
  localparam int ANG_45  = 45;
  localparam int ANG_135 = 135;
  localparam int ANG_225 = 225;
  localparam int ANG_315 = 315;

  typedef enum logic [1:0] {
    DIR_HORIZ,
    DIR_DIAG_A,
    DIR_VERT,
    DIR_DIAG_B
  } dir_t;

  typedef struct packed {
    logic [FIFO_CNT_W-1:0] count;
    logic                  not_empty;
  } fifo_stat_t;

  // first matching test wins, so boundary angles fall to the earlier direction
  function automatic dir_t pick_dir(input logic signed [ANG_BITS-1:0] a);
    int   v;
    dir_t d;
    v = int'(a);
    priority if ((v >= -ANG_45 && v <= ANG_45) || v >= ANG_315 || v <= -ANG_315) begin
      d = DIR_HORIZ;
    end else if ((v >= ANG_45 && v <= ANG_135) || (v >= -ANG_315 && v <= -ANG_225)) begin
      d = DIR_DIAG_A;
    end else if ((v >= ANG_135 && v <= ANG_225) || (v >= -ANG_225 && v <= -ANG_135)) begin
      d = DIR_VERT;
    end else begin
      d = DIR_DIAG_B;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gradient_non_maximum_suppression.sv =====
// Top level: four-direction gradient non-maximum suppression over a raster pixel stream.
// Throughput: one pixel per clock while a FIFO slot is free; the line stores sit in one
// RAM read at acceptance, written back next cycle, always at a different column than the
// next read. A result goes via stages 1, 2 and the FIFO after the pixel ending its 3x3
// window (one row and one column after its centre); border pixels give no transfer.
// Reset (synchronous, rst_n low): counters, window, pipeline and FIFO cleared,
// frame_width 640, frame_height 480; line store contents are not cleared.
`default_nettype none

`include "gradient_non_maximum_suppression_assert.svh"

module gradient_non_maximum_suppression import gnms_pkg::*; #(
  parameter  int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter  int MAG_BITS  = MAG_BITS_DEF,
  localparam int IN_DW     = ((MAG_BITS + ANG_BITS + 7) / 8) * 8,
  localparam int OUT_DW    = ((MAG_BITS + 2 * COORD_BITS + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_DW-1:0]  in_tdata,   // grad_magnitude, grad_angle
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [OUT_DW-1:0] out_tdata,  // kept_magnitude, center_column, center_row
  output logic                   out_tlast,  // frame_done
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [APB_DW-1:0] cfg_pwdata,
  output logic      [APB_DW-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int RAM_W  = 2 * MAG_BITS + ANG_BITS;
  localparam int RES_W  = MAG_BITS + 2 * COORD_BITS + 1;
  localparam int PEND_W = FIFO_CNT_W + 1;

  // configuration
  logic                cfg_wr;
  logic [CFG_BITS-1:0] frame_width_r;
  logic [CFG_BITS-1:0] frame_height_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= CFG_BITS'(FRAME_WIDTH_RESET);
      frame_height_r <= CFG_BITS'(FRAME_HEIGHT_RESET);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[REG_SEL_BIT])
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_pwdata[CFG_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_pwdata[CFG_BITS-1:0];
        default:          frame_width_r  <= frame_width_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[REG_SEL_BIT])
      REG_FRAME_WIDTH:  cfg_prdata = APB_DW'(frame_width_r);
      REG_FRAME_HEIGHT: cfg_prdata = APB_DW'(frame_height_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // position tracking
  logic                  in_accept;
  logic [AW-1:0]         col_r, col_nxt;
  logic [COORD_BITS-1:0] row_r, row_nxt;
  logic [WW-1:0]         w, wm1;
  logic [CFG_BITS-1:0]   h, hm1;
  logic [AW-1:0]         c;
  logic [COORD_BITS-1:0] r;
  logic                  col_last, row_last, produced;
  logic [COORD_BITS-1:0] cen_col, cen_row;

  assign in_accept = in_tvalid & in_tready;

  always_comb begin
    if (32'(frame_width_r) < DIM_MIN) begin
      w = WW'(DIM_MIN);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(frame_width_r);
    end
    if (32'(frame_height_r) < DIM_MIN) begin
      h = CFG_BITS'(DIM_MIN);
    end else if (32'(frame_height_r) > HEIGHT_MAX) begin
      h = CFG_BITS'(HEIGHT_MAX);
    end else begin
      h = frame_height_r;
    end
    wm1 = w - 1'b1;
    hm1 = h - 1'b1;
    c   = (WW'(col_r) >= w) ? wm1[AW-1:0] : col_r;
    r   = (CFG_BITS'(row_r) >= h) ? hm1[COORD_BITS-1:0] : row_r;
    col_last = (WW'(c) == wm1);
    row_last = (CFG_BITS'(r) == hm1);
    produced = (32'(c) >= 2) && (32'(r) >= 2);
    cen_col  = COORD_BITS'(32'(c) - 1);
    cen_row  = COORD_BITS'(32'(r) - 1);
    if (col_last) begin
      col_nxt = '0;
      row_nxt = row_last ? '0 : r + 1'b1;
    end else begin
      col_nxt = c + 1'b1;
      row_nxt = r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage 1: line store data back, window shift, write-back
  logic                  s1_v_r;
  logic [AW-1:0]         s1_addr_r;
  logic [MAG_BITS-1:0]   s1_mag_r;
  logic [ANG_BITS-1:0]   s1_ang_r;
  logic                  s1_prod_r, s1_done_r;
  logic [COORD_BITS-1:0] s1_col_r, s1_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_addr_r <= c;
      s1_mag_r  <= in_tdata[MAG_BITS-1:0];
      s1_ang_r  <= in_tdata[MAG_BITS +: ANG_BITS];
      s1_prod_r <= produced;
      s1_done_r <= col_last & row_last;
      s1_col_r  <= cen_col;
      s1_row_r  <= cen_row;
    end
  end

  // line store word: above magnitude, middle magnitude, middle angle
  logic [RAM_W-1:0]    ram_rdata, ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [MAG_BITS-1:0] rd_above, rd_mid;
  logic [ANG_BITS-1:0] rd_ang;

  assign ram_raddr = c;
  assign rd_above  = ram_rdata[RAM_W-1 -: MAG_BITS];
  assign rd_mid    = ram_rdata[ANG_BITS +: MAG_BITS];
  assign rd_ang    = ram_rdata[ANG_BITS-1:0];
  assign ram_wdata = {rd_mid, s1_mag_r, s1_ang_r};

  gnms_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_addr_r),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic [MAG_BITS-1:0] win_r [3][3];
  logic [ANG_BITS-1:0] ang_d0_r, ang_d1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[k][j] <= '0;
        end
      end
      ang_d0_r <= '0;
      ang_d1_r <= '0;
    end else if (s1_v_r) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= win_r[k][1];
        win_r[k][1] <= win_r[k][2];
      end
      win_r[0][2] <= rd_above;
      win_r[1][2] <= rd_mid;
      win_r[2][2] <= s1_mag_r;
      ang_d0_r    <= ang_d1_r;
      ang_d1_r    <= rd_ang;
    end
  end

  // stage 2: direction pick and local maximum test
  logic                  s2_v_r;
  logic                  s2_prod_r, s2_done_r;
  logic [COORD_BITS-1:0] s2_col_r, s2_row_r;
  dir_t                  dir;
  logic [MAG_BITS-1:0]   centre, n1, n2, kept;
  logic [RES_W-1:0]      res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_prod_r <= s1_prod_r;
      s2_done_r <= s1_done_r;
      s2_col_r  <= s1_col_r;
      s2_row_r  <= s1_row_r;
    end
  end

  always_comb begin
    dir    = pick_dir(ang_d0_r);
    centre = win_r[1][1];
    unique case (dir)
      DIR_HORIZ:  begin n1 = win_r[1][0]; n2 = win_r[1][2]; end
      DIR_DIAG_A: begin n1 = win_r[0][2]; n2 = win_r[2][0]; end
      DIR_VERT:   begin n1 = win_r[0][1]; n2 = win_r[2][1]; end
      DIR_DIAG_B: begin n1 = win_r[0][0]; n2 = win_r[2][2]; end
      default:    begin n1 = win_r[0][0]; n2 = win_r[2][2]; end
    endcase
    kept = (centre >= n1 && centre >= n2) ? centre : '0;
    res  = {s2_done_r, s2_row_r, s2_col_r, kept};
  end

  // result FIFO; every accepted pixel holds a slot while in stage 1 or 2, and a produced result until it is popped
  logic             fifo_push, fifo_pop;
  logic [RES_W-1:0] fifo_rdata;
  fifo_stat_t       fifo_stat;
  logic [PEND_W-1:0] pending;

  assign fifo_push = s2_v_r & s2_prod_r;
  assign fifo_pop  = out_tvalid & out_tready;

  gnms_out_fifo #(
    .WIDTH (RES_W)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fifo_push),
    .push_data (res),
    .pop       (fifo_pop),
    .pop_data  (fifo_rdata),
    .stat      (fifo_stat)
  );

  assign pending    = PEND_W'(fifo_stat.count) + PEND_W'(s1_v_r) + PEND_W'(s2_v_r);
  assign in_tready  = (32'(pending) < FIFO_DEPTH);
  assign out_tvalid = fifo_stat.not_empty;
  assign out_tlast  = fifo_rdata[RES_W-1];
  assign out_tdata  = OUT_DW'(fifo_rdata[RES_W-2:0]);

  `GNMS_ASSERT_NOW(a_line_ram_no_clash, s1_v_r && in_accept, ram_raddr != s1_addr_r, "line store read and write-back hit the same column")
  `GNMS_ASSERT_NEXT(a_s1_follows_accept, in_accept, s1_v_r, "accepted pixel did not reach stage 1")
  `GNMS_ASSERT_NOW(a_slots_bounded, 1'b1, 32'(pending) <= FIFO_DEPTH, "in-flight pixels exceed result FIFO slots")
  `GNMS_ASSERT_NOW(a_push_has_room, fifo_push && !fifo_pop, 32'(fifo_stat.count) < FIFO_DEPTH, "result FIFO overflow")

endmodule

`default_nettype wire

// ===== rtl/gnms_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module gnms_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/gnms_out_fifo.sv =====
// Result FIFO decoupling the suppression pipeline from output back-pressure.
`default_nettype none

module gnms_out_fifo import gnms_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output fifo_stat_t            stat
);

  localparam int PW = $clog2(FIFO_DEPTH);

  logic [WIDTH-1:0]      mem_r [FIFO_DEPTH];
  logic [PW-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data       = mem_r[rd_ptr_r];
  assign stat.count     = count_r;
  assign stat.not_empty = (count_r != '0);

endmodule

`default_nettype wire
